// File: sv/tld_pkg.sv
// tld_pkg: shared types, codes and constants of the terminal line discipline
// no dependencies; used by every module of the block but tld_ring_ram

package tld_pkg;

  // ring and read burst sizing
  localparam int RING_DEPTH = 1024;
  localparam int MAX_READ   = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int LEN_W      = 7;
  localparam int CNT_W      = $clog2(MAX_READ + 1);
  localparam int CMP_W      = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int IDX_W      = 3;

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // command codes
  typedef enum logic [1:0] {
    CMD_RECV  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_OUT   = 2'd0,
    KIND_INTR  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ISIG = 3'd0,
    REG_ECHO = 3'd1,
    REG_CRNL = 3'd2,
    REG_NLCR = 3'd3,
    REG_INTR = 3'd4
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WR2
  } state_t;

  // mode bits seen by the sequencer
  typedef struct packed {
    logic       isig;
    logic       echo;
    logic       crnl;
    logic       nlcr;
    logic [7:0] intr_char;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{isig: 1'b1, echo: 1'b1, crnl: 1'b1, nlcr: 1'b1,
                                 intr_char: 8'h03};

  // ring memory access request
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: sv/tld_ring_ram.sv
// tld_ring_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module tld_ring_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/tld_cfg_regs.sv
// tld_cfg_regs: mode registers written through the configuration channel
// depends on tld_pkg

module tld_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tld_pkg::IDX_W-1:0] cfg_index,
  input  logic [7:0]                cfg_data,
  output tld_pkg::cfg_t             cfg
);

  // the registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // register file, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= tld_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tld_pkg::REG_ISIG: cfg.isig      <= cfg_data[0];
        tld_pkg::REG_ECHO: cfg.echo      <= cfg_data[0];
        tld_pkg::REG_CRNL: cfg.crnl      <= cfg_data[0];
        tld_pkg::REG_NLCR: cfg.nlcr      <= cfg_data[0];
        tld_pkg::REG_INTR: cfg.intr_char <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/tld_ctrl.sv
// tld_ctrl: command sequencer, ring pointers and result register
// depends on tld_pkg; drives the ring ram through a ram_req_t bundle

module tld_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd,
  input  logic [7:0]                data_byte,
  input  logic [tld_pkg::LEN_W-1:0] read_length,
  input  logic                      write_last,
  input  tld_pkg::cfg_t             cfg,
  output tld_pkg::ram_req_t         ram_req,
  input  logic [7:0]                ram_rdata,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [7:0]                out_byte,
  output logic                      last
);

  localparam int PTR_W = tld_pkg::PTR_W;
  localparam int LEN_W = tld_pkg::LEN_W;
  localparam int CNT_W = tld_pkg::CNT_W;
  localparam int CMP_W = tld_pkg::CMP_W;

  tld_pkg::state_t   state, state_next;
  logic [PTR_W-1:0]  rp, rp_next, wp, wp_next;
  logic              stopped, stopped_next;
  logic [CNT_W-1:0]  left, left_next;
  logic              strobe_r, strobe_next;
  tld_pkg::kind_t    kind_r, kind_next;
  logic [7:0]        byte_r, byte_next;
  logic              last_r, last_next;
  logic              from_ram, from_ram_next;

  logic              accept;
  logic [PTR_W-1:0]  rp_inc, wp_inc;
  logic              full;
  logic [PTR_W:0]    diff;
  logic [PTR_W-1:0]  avail;
  logic [LEN_W-1:0]  len_sat;
  logic [CNT_W-1:0]  n;
  logic [7:0]        echo_byte;

  assign accept = start && (state == tld_pkg::ST_IDLE);
  assign busy   = (state != tld_pkg::ST_IDLE);

  // pointer increments with wrap at the ring depth
  assign rp_inc = (rp == PTR_W'(tld_pkg::RING_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign wp_inc = (wp == PTR_W'(tld_pkg::RING_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign full   = (wp_inc == rp);

  // fill level of the ring
  always_comb begin
    diff = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      diff = diff + (PTR_W + 1)'(tld_pkg::RING_DEPTH);
    end
    avail = diff[PTR_W-1:0];
  end

  // burst length: saturate the request, then clip to the fill level
  assign len_sat = (read_length > LEN_W'(tld_pkg::MAX_READ)) ?
                   LEN_W'(tld_pkg::MAX_READ) : read_length;
  assign n = (CMP_W'(avail) < CMP_W'(len_sat)) ? CNT_W'(avail) : CNT_W'(len_sat);

  // received byte after the optional cr to nl map
  assign echo_byte = (cfg.crnl && data_byte == tld_pkg::CH_CR) ? tld_pkg::CH_NL : data_byte;

  // next state and result
  always_comb begin
    state_next    = state;
    rp_next       = rp;
    wp_next       = wp;
    stopped_next  = stopped;
    left_next     = left;
    strobe_next   = 1'b0;
    kind_next     = kind_r;
    byte_next     = byte_r;
    last_next     = last_r;
    from_ram_next = 1'b0;
    ram_req       = '0;
    ram_req.waddr = wp;
    ram_req.wdata = data_byte;
    ram_req.raddr = rp;

    unique case (state)
      tld_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            tld_pkg::CMD_RECV: begin
              if (!full) begin
                ram_req.we = 1'b1;
                wp_next    = wp_inc;
                if (cfg.isig && data_byte == cfg.intr_char) begin
                  strobe_next = 1'b1;
                  kind_next   = tld_pkg::KIND_INTR;
                  byte_next   = '0;
                  last_next   = 1'b1;
                end else if (cfg.echo) begin
                  strobe_next = 1'b1;
                  kind_next   = tld_pkg::KIND_OUT;
                  byte_next   = echo_byte;
                  last_next   = 1'b1;
                end
              end
            end
            tld_pkg::CMD_READ: begin
              strobe_next = 1'b1;
              if (n == '0) begin
                kind_next = tld_pkg::KIND_EMPTY;
                byte_next = '0;
                last_next = 1'b1;
              end else begin
                ram_req.re    = 1'b1;
                rp_next       = rp_inc;
                kind_next     = tld_pkg::KIND_DATA;
                from_ram_next = 1'b1;
                last_next     = (n == CNT_W'(1));
                left_next     = n - 1'b1;
                if (n != CNT_W'(1)) begin
                  state_next = tld_pkg::ST_READ;
                end
              end
            end
            tld_pkg::CMD_WRITE: begin
              if (stopped) begin
                if (write_last) begin
                  stopped_next = 1'b0;
                end
              end else if (data_byte == tld_pkg::CH_NUL) begin
                if (!write_last) begin
                  stopped_next = 1'b1;
                end
              end else if (cfg.nlcr && data_byte == tld_pkg::CH_NL) begin
                strobe_next = 1'b1;
                kind_next   = tld_pkg::KIND_OUT;
                byte_next   = tld_pkg::CH_CR;
                last_next   = 1'b0;
                state_next  = tld_pkg::ST_WR2;
              end else begin
                strobe_next = 1'b1;
                kind_next   = tld_pkg::KIND_OUT;
                byte_next   = data_byte;
                last_next   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      // one ring read per cycle, data lands with the strobe
      tld_pkg::ST_READ: begin
        ram_req.re    = 1'b1;
        rp_next       = rp_inc;
        strobe_next   = 1'b1;
        kind_next     = tld_pkg::KIND_DATA;
        from_ram_next = 1'b1;
        last_next     = (left == CNT_W'(1));
        left_next     = left - 1'b1;
        if (left == CNT_W'(1)) begin
          state_next = tld_pkg::ST_IDLE;
        end
      end
      // newline that follows the inserted carriage return
      tld_pkg::ST_WR2: begin
        strobe_next = 1'b1;
        kind_next   = tld_pkg::KIND_OUT;
        byte_next   = tld_pkg::CH_NL;
        last_next   = 1'b1;
        state_next  = tld_pkg::ST_IDLE;
      end
      default: state_next = tld_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tld_pkg::ST_IDLE;
      rp       <= '0;
      wp       <= '0;
      stopped  <= 1'b0;
      left     <= '0;
      strobe_r <= 1'b0;
      from_ram <= 1'b0;
    end else begin
      state    <= state_next;
      rp       <= rp_next;
      wp       <= wp_next;
      stopped  <= stopped_next;
      left     <= left_next;
      strobe_r <= strobe_next;
      from_ram <= from_ram_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind_r <= kind_next;
    byte_r <= byte_next;
    last_r <= last_next;
  end

  assign strobe   = strobe_r;
  assign kind     = kind_r;
  assign out_byte = from_ram ? ram_rdata : byte_r;
  assign last     = last_r;

`ifndef SYNTHESIS
  // a burst state always emits a data result in the next cycle
  a_read_emits: assert property (@(posedge clk) disable iff (rst)
    (state == tld_pkg::ST_READ) |=> (strobe && kind == tld_pkg::KIND_DATA))
    else $error("read burst cycle without a data result");

  // the carriage return goes out while the newline is pending
  a_cr_before_nl: assert property (@(posedge clk) disable iff (rst)
    (state == tld_pkg::ST_WR2) |-> (strobe && out_byte == tld_pkg::CH_CR && !last))
    else $error("newline expansion without a leading carriage return");

  // a result that is not the last one of its item is followed by another
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("result sequence broken before its last result");

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rp <= PTR_W'(tld_pkg::RING_DEPTH - 1)) && (wp <= PTR_W'(tld_pkg::RING_DEPTH - 1)))
    else $error("ring pointer out of range");
`endif

endmodule

// File: sv/terminal_line_discipline.sv
// Terminal line discipline over a byte ring held in one synchronous ram. A command is
// taken when start is high and busy is low; its results come one per cycle on
// strobe/kind/out_byte/last, the first one in the cycle after acceptance, and cannot be
// stalled. A written newline with carriage return insertion gives a carriage return and
// then a newline; a read of n bytes is served by the single read port of the ring ram,
// one byte per cycle, with busy high until the last read is issued. Reset needs no
// clearing pass: only written ring entries are ever read.
// Depends on tld_pkg, tld_cfg_regs, tld_ring_ram and tld_ctrl.

module terminal_line_discipline (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd,
  input  logic [7:0]                data_byte,
  input  logic [tld_pkg::LEN_W-1:0] read_length,
  input  logic                      write_last,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [7:0]                out_byte,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tld_pkg::IDX_W-1:0] cfg_index,
  input  logic [7:0]                cfg_data
);

  tld_pkg::cfg_t     cfg;
  tld_pkg::ram_req_t ram_req;
  logic [7:0]        ram_rdata;

  // mode registers
  tld_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // byte ring storage
  tld_ring_ram #(
    .DEPTH  (tld_pkg::RING_DEPTH),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  tld_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .read_length (read_length),
    .write_last  (write_last),
    .cfg         (cfg),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .strobe      (strobe),
    .kind        (kind),
    .out_byte    (out_byte),
    .last        (last)
  );

endmodule
